/* rtl/klc_pkg.sv */
// Shared types and constants for the keyed LRU entry cache.
// No dependencies; the cache, cell and checker files import this package.
package klc_pkg;

    // Cache geometry and lookup limits
    localparam int ENTRIES   = 4;
    localparam int MAX_VIEWS = 8;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // FNV-1a offset basis: a hash equal to it marks an unhashed key
    localparam logic [63:0] FNV_OFFSET = 64'hCBF2_9CE4_8422_2325;

    typedef enum logic [1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_MARK   = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_HIT    = 2'd0,
        ST_MISS   = 2'd1,
        ST_REJECT = 2'd2,
        ST_DONE   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_TOUCH,
        OP_ALLOC,
        OP_MARK,
        OP_CLEAR
    } op_t;

    // Key broadcast to every cell during a scan
    typedef struct packed {
        logic [63:0] tag;
        logic [3:0]  count;
        logic        force_clear;
    } key_t;

    // Running scan record handed from cell to cell
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] hit_idx;
        logic             have;
        logic [31:0]      old_time;
        logic [IDX_W-1:0] old_idx;
        logic [IDX_W-1:0] pos;
    } scan_t;

    // Write command broadcast to the cells
    typedef struct packed {
        op_t         op;
        logic [31:0] frame;
        logic [63:0] tag;
        logic [3:0]  count;
    } wr_cmd_t;

endpackage

/* rtl/klc_if.sv */
// Handshake interfaces for the request and response channels.
// Does not depend on klc_pkg; the widths are written out directly.
interface klc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] frame_serial;
    logic [63:0] key_hash;
    logic        key_fields_ok;
    logic [3:0]  sub_count;
    logic        force_clear;
    logic [1:0]  target_entry;

    modport source (
        output valid, kind, frame_serial, key_hash, key_fields_ok,
               sub_count, force_clear, target_entry,
        input  ready
    );
    modport sink (
        input  valid, kind, frame_serial, key_hash, key_fields_ok,
               sub_count, force_clear, target_entry,
        output ready
    );
endinterface

interface klc_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [1:0] entry_index;
    logic       needs_rebuild;

    modport source (
        output valid, status, entry_index, needs_rebuild,
        input  ready
    );
    modport sink (
        input  valid, status, entry_index, needs_rebuild,
        output ready
    );
endinterface

/* rtl/keyed_lru_entry_cache.sv */
// Top level of the keyed LRU entry cache: request control, the row of
// entry cells and the response register. Depends on klc_pkg, klc_if, klc_cell.
//
// Usage:
//   req carries one request (lookup, mark built, clear all); rsp returns
//   exactly one response per request: status, entry_index, needs_rebuild.
//   A request is taken when req.valid and req.ready are high at a clock edge.
//   req.ready is high only while no request is in work, so requests are
//   handled one at a time.
//   A lookup walks a scan record along the row of ENTRIES cells, one cell a
//   cycle, then writes back; a new request may be taken as soon as the
//   response is valid.
//   Mark, clear, rejected lookups and unused kinds skip the scan and go
//   straight to write-back. The cell row length sets how long a lookup takes.
//   A finished response sits in the response register; the block takes the
//   next request while it waits, but holds the following write-back until
//   rsp.ready frees the register, so a stalled receiver loses nothing.
//   Reset (rst_n low, asynchronous) empties all entries: not valid, tag,
//   count and timestamp zero; no response is pending afterwards.
module keyed_lru_entry_cache
    import klc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    klc_req_if.sink   req,
    klc_rsp_if.source rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY
    } state_t;

    state_t           state_reg, state_next;
    kind_t            kind_reg, kind_next;
    logic [31:0]      frame_reg, frame_next;
    logic [63:0]      hash_reg, hash_next;
    logic [3:0]       count_reg, count_next;
    logic             force_reg, force_next;
    logic [1:0]       target_reg, target_next;
    status_t          res_status_reg, res_status_next;
    logic [IDX_W-1:0] res_idx_reg, res_idx_next;
    logic             scan_start_reg, scan_start_next;
    logic             rsp_valid_reg, rsp_valid_next;
    status_t          rsp_status_reg, rsp_status_next;
    logic [1:0]       rsp_idx_reg, rsp_idx_next;
    logic             rsp_rebuild_reg, rsp_rebuild_next;

    logic             accept;
    logic             slot_free;
    logic             apply_go;
    logic             rejected;
    key_t             key;
    wr_cmd_t          cmd;
    logic [ENTRIES-1:0] sel;
    logic             chain_vld [ENTRIES+1];
    scan_t            chain_rec [ENTRIES+1];

    assign accept    = req.valid && req.ready;
    assign slot_free = !rsp_valid_reg || rsp.ready;
    assign apply_go  = (state_reg == S_APPLY) && slot_free;
    assign req.ready = (state_reg == S_IDLE);

    // Screen a lookup for bad frame, bad key or too many views
    assign rejected = (req.frame_serial == 32'd0) || (req.key_hash == 64'd0)
                      || (req.key_hash == FNV_OFFSET) || !req.key_fields_ok
                      || (req.sub_count > 4'(MAX_VIEWS));

    // Request control
    always_comb
    begin
        state_next       = state_reg;
        kind_next        = kind_reg;
        frame_next       = frame_reg;
        hash_next        = hash_reg;
        count_next       = count_reg;
        force_next       = force_reg;
        target_next      = target_reg;
        res_status_next  = res_status_reg;
        res_idx_next     = res_idx_reg;
        scan_start_next  = 1'b0;
        rsp_valid_next   = rsp_valid_reg && !rsp.ready;
        rsp_status_next  = rsp_status_reg;
        rsp_idx_next     = rsp_idx_reg;
        rsp_rebuild_next = rsp_rebuild_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next    = kind_t'(req.kind);
                    frame_next   = req.frame_serial;
                    hash_next    = req.key_hash;
                    count_next   = req.sub_count;
                    force_next   = req.force_clear;
                    target_next  = req.target_entry;
                    res_idx_next = '0;
                    state_next   = S_APPLY;
                    case (kind_t'(req.kind))
                        KIND_MARK, KIND_CLEAR:
                        begin
                            res_status_next = ST_DONE;
                        end
                        KIND_LOOKUP:
                        begin
                            if (rejected)
                            begin
                                res_status_next = ST_REJECT;
                            end
                            else
                            begin
                                scan_start_next = 1'b1;
                                state_next      = S_SCAN;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_REJECT;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (chain_vld[ENTRIES])
                begin
                    if (chain_rec[ENTRIES].found)
                    begin
                        res_status_next = ST_HIT;
                        res_idx_next    = chain_rec[ENTRIES].hit_idx;
                    end
                    else
                    begin
                        res_status_next = ST_MISS;
                        res_idx_next    = chain_rec[ENTRIES].old_idx;
                    end
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (slot_free)
                begin
                    rsp_valid_next   = 1'b1;
                    rsp_status_next  = res_status_reg;
                    rsp_idx_next     = 2'(res_idx_reg);
                    rsp_rebuild_next = (res_status_reg == ST_MISS);
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, request and response registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            kind_reg        <= KIND_LOOKUP;
            frame_reg       <= '0;
            hash_reg        <= '0;
            count_reg       <= '0;
            force_reg       <= 1'b0;
            target_reg      <= '0;
            res_status_reg  <= ST_REJECT;
            res_idx_reg     <= '0;
            scan_start_reg  <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            rsp_status_reg  <= ST_REJECT;
            rsp_idx_reg     <= '0;
            rsp_rebuild_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            kind_reg        <= kind_next;
            frame_reg       <= frame_next;
            hash_reg        <= hash_next;
            count_reg       <= count_next;
            force_reg       <= force_next;
            target_reg      <= target_next;
            res_status_reg  <= res_status_next;
            res_idx_reg     <= res_idx_next;
            scan_start_reg  <= scan_start_next;
            rsp_valid_reg   <= rsp_valid_next;
            rsp_status_reg  <= rsp_status_next;
            rsp_idx_reg     <= rsp_idx_next;
            rsp_rebuild_reg <= rsp_rebuild_next;
        end
    end

    // Broadcast key and write-back command
    assign key.tag         = hash_reg;
    assign key.count       = count_reg;
    assign key.force_clear = force_reg;

    always_comb
    begin
        cmd.op    = OP_NONE;
        cmd.frame = frame_reg;
        cmd.tag   = hash_reg;
        cmd.count = count_reg;
        if (apply_go)
        begin
            case (res_status_reg)
                ST_HIT:  cmd.op = OP_TOUCH;
                ST_MISS: cmd.op = OP_ALLOC;
                ST_DONE:
                begin
                    if (kind_reg == KIND_MARK)
                    begin
                        cmd.op = OP_MARK;
                    end
                    else if (kind_reg == KIND_CLEAR)
                    begin
                        cmd.op = OP_CLEAR;
                    end
                end
                default: cmd.op = OP_NONE;
            endcase
        end
    end

    // Select the written cell: scan result for lookups, target for marks
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (kind_reg == KIND_MARK)
            begin
                sel[i] = (i < 4) && (target_reg == 2'(i));
            end
            else
            begin
                sel[i] = (res_idx_reg == IDX_W'(i));
            end
        end
    end

    // Seed the scan record at the head of the row
    assign chain_vld[0]          = scan_start_reg;
    assign chain_rec[0].found    = 1'b0;
    assign chain_rec[0].hit_idx  = '0;
    assign chain_rec[0].have     = 1'b0;
    assign chain_rec[0].old_time = '0;
    assign chain_rec[0].old_idx  = '0;
    assign chain_rec[0].pos      = '0;

    // Row of entry cells
    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        klc_cell u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .key            (key),
            .cmd            (cmd),
            .sel            (sel[g]),
            .scan_in_valid  (chain_vld[g]),
            .scan_in        (chain_rec[g]),
            .scan_out_valid (chain_vld[g+1]),
            .scan_out       (chain_rec[g+1])
        );
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = rsp_status_reg;
    assign rsp.entry_index   = rsp_idx_reg;
    assign rsp.needs_rebuild = rsp_rebuild_reg;

endmodule

/* rtl/klc_cell.sv */
// One cache entry cell: holds valid, tag, count and timestamp, and folds
// itself into the scan record passed along the chain. Depends on klc_pkg.
module klc_cell
    import klc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  key_t    key,
    input  wr_cmd_t cmd,
    input  logic    sel,
    input  logic    scan_in_valid,
    input  scan_t   scan_in,
    output logic    scan_out_valid,
    output scan_t   scan_out
);

    logic        valid_reg, valid_next;
    logic [63:0] tag_reg, tag_next;
    logic [3:0]  count_reg, count_next;
    logic [31:0] time_reg, time_next;
    logic        scan_valid_reg;
    scan_t       scan_reg, scan_next;
    logic        match;

    // Compare this entry against the broadcast key
    assign match = valid_reg && (tag_reg == key.tag) && (count_reg == key.count)
                   && !key.force_clear;

    // Fold this entry into the running record: first hit, oldest time
    always_comb
    begin
        scan_next     = scan_in;
        scan_next.pos = scan_in.pos + IDX_W'(1);
        if (!scan_in.found && match)
        begin
            scan_next.found   = 1'b1;
            scan_next.hit_idx = scan_in.pos;
        end
        if (!scan_in.have || (time_reg < scan_in.old_time))
        begin
            scan_next.have     = 1'b1;
            scan_next.old_time = time_reg;
            scan_next.old_idx  = scan_in.pos;
        end
    end

    // Apply broadcast writes
    always_comb
    begin
        valid_next = valid_reg;
        tag_next   = tag_reg;
        count_next = count_reg;
        time_next  = time_reg;
        case (cmd.op)
            OP_CLEAR:
            begin
                valid_next = 1'b0;
                tag_next   = '0;
                count_next = '0;
                time_next  = '0;
            end
            OP_TOUCH:
            begin
                if (sel)
                begin
                    time_next = cmd.frame;
                end
            end
            OP_ALLOC:
            begin
                if (sel)
                begin
                    valid_next = 1'b0;
                    tag_next   = cmd.tag;
                    count_next = cmd.count;
                    time_next  = cmd.frame;
                end
            end
            OP_MARK:
            begin
                if (sel)
                begin
                    valid_next = 1'b1;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    // Hold entry state and advance the scan stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            tag_reg        <= '0;
            count_reg      <= '0;
            time_reg       <= '0;
            scan_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            tag_reg        <= tag_next;
            count_reg      <= count_next;
            time_reg       <= time_next;
            scan_valid_reg <= scan_in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
    end

    assign scan_out_valid = scan_valid_reg;
    assign scan_out       = scan_reg;

endmodule

/* rtl/klc_checker.sv */
// Port-level checks for the keyed LRU entry cache, bound to the top level.
// Depends on klc_pkg and keyed_lru_entry_cache.
module klc_checker
    import klc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [1:0] rsp_status,
    input logic [1:0] rsp_entry_index,
    input logic       rsp_needs_rebuild
);

    // A stalled response holds its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
        && $stable(rsp_entry_index) && $stable(rsp_needs_rebuild))
        else $error("response changed while stalled");

    // Rebuild is flagged exactly on a miss allocation
    a_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_needs_rebuild == (rsp_status == ST_MISS)))
        else $error("rebuild flag disagrees with status");

    // Only hits and misses carry an entry index
    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_REJECT || rsp_status == ST_DONE)
        |-> (rsp_entry_index == 2'd0))
        else $error("entry index set on reject or done");

    // Requests are handled one at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in work");

endmodule

bind keyed_lru_entry_cache klc_checker u_klc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_status        (rsp.status),
    .rsp_entry_index   (rsp.entry_index),
    .rsp_needs_rebuild (rsp.needs_rebuild)
);
